[hdl/luma_box_blur_macros.svh]
// assertion macros shared by the luma box blur rtl
// no dependencies; define SYNTH to compile the assertions out
`ifndef LUMA_BOX_BLUR_MACROS_SVH
`define LUMA_BOX_BLUR_MACROS_SVH

`ifndef SYNTH

// assertion on an explicit clock and active-low reset
`define LBB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the module's own clk and rst_n
`define LBB_ASSERT(label, prop, msg) \
    `LBB_ASSERT_CLK(label, clk, rst_n, prop, msg)

`else

`define LBB_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define LBB_ASSERT(label, prop, msg)

`endif

`endif

[hdl/lbb_pkg.sv]
// shared types, register map and divide helpers for the luma box blur
// no dependencies
package lbb_pkg;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // mode register codes
    localparam logic MODE_HORIZONTAL = 1'b0;
    localparam logic MODE_BOX        = 1'b1;

    // register reset values
    localparam logic        MODE_RESET   = 1'b0;
    localparam logic [11:0] WIDTH_RESET  = 12'd720;
    localparam logic [11:0] HEIGHT_RESET = 12'd576;

    // output queue sizing
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
    localparam logic [OUT_CW:0] STALL_LEVEL = (OUT_CW + 1)'(OUT_DEPTH - 2);

    // one result transaction
    typedef struct packed {
        logic [7:0] pixel;
        logic       eol;
        logic       eof;
    } lbb_result_t;

    // results produced by one pixel, in order
    typedef struct packed {
        logic [1:0]  count;
        lbb_result_t first;
        lbb_result_t second;
    } lbb_push_t;

    // floor(x / 3) for x up to 765, reciprocal 21846 / 2^16
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [25:0] p;
        p = {16'b0, x} * 26'd21846;
        return p[23:16];
    endfunction

    // floor(x / 9) for x up to 2295, reciprocal 7282 / 2^16
    function automatic logic [7:0] div9(input logic [11:0] x);
        logic [25:0] p;
        p = {14'b0, x} * 26'd7282;
        return p[23:16];
    endfunction

endpackage

[hdl/lbb_line_store.sv]
// two-line pixel store, one entry holds {previous line, current line}
// registered read with write-first forwarding; no package dependencies
module lbb_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);

    logic [15:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, same-address write wins
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

[hdl/lbb_out_fifo.sv]
// output queue, takes up to two results a cycle and gives one while out_stall is low
// depends on lbb_pkg and luma_box_blur_macros.svh
`include "luma_box_blur_macros.svh"

module lbb_out_fifo
    import lbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lbb_push_t         push,
    output logic              out_valid,
    input  logic              out_stall,
    output lbb_result_t       out_item,
    output logic [OUT_CW-1:0] level
);

    lbb_result_t       entry_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] head_reg;
    logic [OUT_AW-1:0] head_next;
    logic [OUT_AW-1:0] tail_reg;
    logic [OUT_AW-1:0] tail_next;
    logic [OUT_CW-1:0] count_reg;
    logic [OUT_CW-1:0] count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[head_reg];
    assign level     = count_reg;
    assign pop       = out_valid && !out_stall;

    // pointer and level update
    always_comb
    begin
        head_next  = pop ? head_reg + OUT_AW'(1) : head_reg;
        tail_next  = tail_reg + OUT_AW'(push.count);
        count_next = count_reg + OUT_CW'(push.count) - OUT_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry writes, second result goes one slot after the first
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_reg + OUT_AW'(1)] <= push.second;
        end
    end

    `LBB_ASSERT(a_no_overflow, ({1'b0, count_reg} + (OUT_CW + 1)'(push.count)) <= (OUT_CW + 1)'(OUT_DEPTH), "output queue overflow")

endmodule

[hdl/luma_box_blur.sv]
// luma box blur top level: register port, counters, window and arithmetic
// depends on lbb_pkg, lbb_line_store, lbb_out_fifo, luma_box_blur_macros.svh
//
// usage
//   pixels enter in raster order on in_valid / in_stall with pixel_in and
//   start_of_frame; a transaction is taken when in_valid is high and
//   in_stall is low. blurred pixels leave on out_valid / out_stall with
//   pixel_out, end_of_line and end_of_frame.
//   mode 0 gives each line one pixel behind the input; mode 1 gives the
//   3x3 result one line plus one pixel behind, and the last line of a frame
//   comes out while the first line of the next frame goes in.
//   one pixel is taken every cycle while in_stall is low: column 0 gives no
//   result and the last column gives two, so a line of w pixels gives w
//   results, and an 8-entry output queue absorbs the burst. an accepted
//   pixel and its line store read are registered in the result stage, then
//   the window and divide write its results into the queue.
//   in_stall rises when the output queue could not hold the results of the
//   pixels in flight, so a stalled receiver backs up to the input and
//   nothing is dropped.
//   registers (apb, 4-byte spacing): mode, frame_width, frame_height; write
//   them only while the block is idle.
//   reset clears counters, window, queue and registers; the line store is
//   not cleared and there is no start-up pass.
`include "luma_box_blur_macros.svh"

module luma_box_blur
    import lbb_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_in,
    input  logic        start_of_frame,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_out,
    output logic        end_of_line,
    output logic        end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam logic [LW-1:0] W_MAX = LW'(MAX_WIDTH);
    localparam logic [LW-1:0] W_MIN = LW'(3);

    // configuration registers
    logic        mode_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        cfg_write;

    // position state
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [11:0]   row_reg;
    logic [11:0]   row_next;
    logic          tail_reg;
    logic          tail_next;

    // pixel-stage decode
    logic          accept;
    logic          sof_hit;
    logic [CW-1:0] col_cur;
    logic [11:0]   row_cur;
    logic          tail_cur;
    logic [LW-1:0] width_eff;
    logic [11:0]   height_eff;
    logic          last_col;
    logic          last_row;
    logic          row_past;

    // result-stage registers
    logic          s1_valid_reg;
    logic [7:0]    s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_first_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic          s1_mode_reg;
    logic          s1_mean3_reg;
    logic          s1_eof_reg;

    // window and arithmetic
    logic [7:0]  win_reg [3][3];
    logic [15:0] line_rd;
    logic [7:0]  top_pix;
    logic [7:0]  mid_pix;
    logic [9:0]  sum_top;
    logic [9:0]  sum_mid;
    logic [9:0]  sum_bot;
    logic [11:0] sum_all;
    lbb_push_t   push;

    // output queue
    lbb_result_t       out_item;
    logic [OUT_CW-1:0] out_level;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[11:0];
                REG_HEIGHT: height_reg <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {31'b0, mode_reg};
            REG_WIDTH:  prdata = {20'b0, width_reg};
            REG_HEIGHT: prdata = {20'b0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // input handshake, room for this pixel's and the staged pixel's results
    assign in_stall = ({1'b0, out_level} + (OUT_CW + 1)'(push.count)) > STALL_LEVEL;
    assign accept   = in_valid && !in_stall;

    // effective frame size
    always_comb
    begin
        if (LW'(width_reg) < W_MIN)
        begin
            width_eff = W_MIN;
        end
        else if (LW'(width_reg) > W_MAX)
        begin
            width_eff = W_MAX;
        end
        else
        begin
            width_eff = LW'(width_reg);
        end
        height_eff = (height_reg < 12'd3) ? 12'd3 : height_reg;
    end

    // position of the incoming pixel, frame mark restarts mid-frame
    always_comb
    begin
        sof_hit  = start_of_frame && ((col_reg != '0) || (row_reg != '0));
        col_cur  = sof_hit ? '0 : col_reg;
        row_cur  = sof_hit ? '0 : row_reg;
        tail_cur = sof_hit ? 1'b0 : tail_reg;
        last_col = (LW'(col_cur) + LW'(1)) >= width_eff;
        last_row = row_cur >= (height_eff - 12'd1);
        row_past = row_cur >= height_eff;
    end

    // counter advance
    always_comb
    begin
        col_next  = col_cur + CW'(1);
        row_next  = row_cur;
        tail_next = tail_cur;
        if (last_col)
        begin
            col_next = '0;
            if (row_cur == '0)
            begin
                tail_next = 1'b0;
            end
            if (last_row)
            begin
                row_next  = '0;
                tail_next = mode_reg;
            end
            else
            begin
                row_next = row_cur + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            tail_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            tail_reg <= tail_next;
        end
    end

    // line store, read on accept and written back by the result stage
    lbb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (line_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_pix, s1_pix_reg})
    );

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // result stage payload, decided from the pixel's position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel_in;
            s1_col_reg   <= col_cur;
            s1_first_reg <= (col_cur == CW'(1));
            s1_emit_reg  <= (col_cur != '0)
                            && (!mode_reg || (row_cur != '0) || tail_cur);
            s1_last_reg  <= last_col;
            s1_mode_reg  <= mode_reg;
            // output row is one line up; first or last output row uses 1x3
            s1_mean3_reg <= (row_cur == '0) || (row_cur == 12'd1) || row_past;
            s1_eof_reg   <= mode_reg ? ((row_cur == '0) || row_past) : last_row;
        end
    end

    // window sums over the shifted-in column
    assign top_pix = line_rd[15:8];
    assign mid_pix = line_rd[7:0];

    always_comb
    begin
        sum_top = 10'(win_reg[0][1]) + 10'(win_reg[0][2]) + 10'(top_pix);
        sum_mid = 10'(win_reg[1][1]) + 10'(win_reg[1][2]) + 10'(mid_pix);
        sum_bot = 10'(win_reg[2][1]) + 10'(win_reg[2][2]) + 10'(s1_pix_reg);
        sum_all = 12'(sum_top) + 12'(sum_mid) + 12'(sum_bot);
    end

    // results of the staged pixel
    always_comb
    begin
        push.second.eol = 1'b1;
        push.second.eof = s1_eof_reg;
        push.first.eol  = 1'b0;
        push.first.eof  = 1'b0;
        if (!s1_mode_reg)
        begin
            push.first.pixel  = s1_first_reg ? win_reg[2][2] : div3(sum_bot);
            push.second.pixel = s1_pix_reg;
        end
        else
        begin
            if (s1_first_reg)
            begin
                push.first.pixel = win_reg[1][2];
            end
            else if (s1_mean3_reg)
            begin
                push.first.pixel = div3(sum_mid);
            end
            else
            begin
                push.first.pixel = div9(sum_all);
            end
            push.second.pixel = mid_pix;
        end
        if (!s1_valid_reg || !s1_emit_reg)
        begin
            push.count = 2'd0;
        end
        else if (s1_last_reg)
        begin
            push.count = 2'd2;
        end
        else
        begin
            push.count = 2'd1;
        end
    end

    // 3x3 window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // output queue
    lbb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .level     (out_level)
    );

    assign pixel_out    = out_item.pixel;
    assign end_of_line  = out_item.eol;
    assign end_of_frame = out_item.eof;

    `LBB_ASSERT(a_stage_follows_accept, accept |=> s1_valid_reg, "accepted pixel did not reach the result stage")
    `LBB_ASSERT(a_col0_no_result, (s1_valid_reg && (s1_col_reg == '0)) |-> (push.count == 2'd0), "column 0 produced a result")
    `LBB_ASSERT(a_pair_only_last, (push.count == 2'd2) |-> s1_last_reg, "two results away from the last column")

endmodule

[tb/sv/luma_box_blur_checker.sv]
`timescale 1ns / 100ps
// checker for the luma box blur: follows the register port and both pixel channels,
// predicts every blurred result transaction and compares it with the block's output
// depends on lbb_pkg for the register map, reset values and the result struct

module luma_box_blur_checker
    import lbb_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  pixel_in,
    input  logic        start_of_frame,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  pixel_out,
    input  logic        end_of_line,
    input  logic        end_of_frame,
    output int          mismatches,
    output int          outstanding
);

    // predicted copy of the block state
    logic [7:0]  upper_line [MAX_WIDTH];
    logic [7:0]  middle_line [MAX_WIDTH];
    logic [7:0]  win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    logic        tail_due;
    logic        mode_sel;
    logic [11:0] width_cfg;
    logic [11:0] height_cfg;

    // blurred pixels still to come, oldest first
    lbb_result_t blur_expected [$];
    lbb_result_t oldest;
    int          k;

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] mean_of_row(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        logic [9:0] s;
        s = 10'(a) + 10'(b) + 10'(c);
        return 8'(s / 10'd3);
    endfunction

    function automatic logic [7:0] mean_of_window();
        logic [11:0] s;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s = s + 12'(win[i][j]);
            end
        end
        return 8'(s / 12'd9);
    endfunction

    task automatic queue_result(input logic [7:0] pix, input logic eol, input logic eof);
        lbb_result_t res;
        res.pixel = pix;
        res.eol   = eol;
        res.eof   = eof;
        blur_expected.push_back(res);
    endtask

    // one accepted pixel: advance window, line stores and counters
    task automatic blur_step(input logic [7:0] pix, input logic sof);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned orow;
        logic        last_col;
        logic [7:0]  v;
        w = width_cfg;
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = height_cfg;
        if (h < 3)
            h = 3;

        // a mark away from the origin restarts the frame and drops the tail
        if (sof && (col_pos != 0 || row_pos != 0))
        begin
            col_pos  = 0;
            row_pos  = 0;
            tail_due = 1'b0;
        end
        c = col_pos;
        r = row_pos;

        // shift the window and load the new column
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = pix;
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;

        last_col = (c >= w - 1);

        // results for the column before, and the edge pixel on the last column
        if (c >= 1)
        begin
            if (mode_sel == MODE_HORIZONTAL)
            begin
                v = (c == 1) ? win[2][1] : mean_of_row(win[2][0], win[2][1], win[2][2]);
                queue_result(v, 1'b0, 1'b0);
                if (last_col)
                    queue_result(win[2][2], 1'b1, r >= h - 1);
            end
            else if (r != 0 || tail_due)
            begin
                orow = (r == 0) ? h - 1 : r - 1;
                if (c == 1)
                    v = win[1][1];
                else if (orow == 0 || orow >= h - 1)
                    v = mean_of_row(win[1][0], win[1][1], win[1][2]);
                else
                    v = mean_of_window();
                queue_result(v, 1'b0, 1'b0);
                if (last_col)
                    queue_result(win[1][2], 1'b1, orow >= h - 1);
            end
        end

        // counters
        if (last_col)
        begin
            col_pos = 0;
            if (r == 0)
                tail_due = 1'b0;
            if (r >= h - 1)
            begin
                row_pos  = 0;
                tail_due = (mode_sel != MODE_HORIZONTAL);
            end
            else
            begin
                row_pos = r + 1;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    // watch pixel transactions, register writes and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < MAX_WIDTH; k++)
            begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (k = 0; k < 9; k++)
            begin
                win[k / 3][k % 3] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            tail_due   = 1'b0;
            mode_sel   = MODE_RESET;
            width_cfg  = WIDTH_RESET;
            height_cfg = HEIGHT_RESET;
            blur_expected.delete();
            outstanding <= 0;
        end
        else
        begin
            // a pixel taken at the same edge as a write still sees the old registers
            if (in_valid && !in_stall)
                blur_step(pixel_in, start_of_frame);

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MODE:   mode_sel   = pwdata[0];
                    REG_WIDTH:  width_cfg  = pwdata[11:0];
                    REG_HEIGHT: height_cfg = pwdata[11:0];
                    default:    ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (blur_expected.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected: pixel %0d eol %0b eof %0b",
                                              pixel_out, end_of_line, end_of_frame));
                end
                else
                begin
                    oldest = blur_expected.pop_front();
                    if (pixel_out !== oldest.pixel)
                        report_mismatch($sformatf("pixel_out got %0d expected %0d",
                                                  pixel_out, oldest.pixel));
                    if (end_of_line !== oldest.eol)
                        report_mismatch($sformatf("end_of_line got %0b expected %0b",
                                                  end_of_line, oldest.eol));
                    if (end_of_frame !== oldest.eof)
                        report_mismatch($sformatf("end_of_frame got %0b expected %0b",
                                                  end_of_frame, oldest.eof));
                end
            end

            outstanding <= blur_expected.size();
        end
    end

endmodule

[tb/sv/luma_box_blur_tb.sv]
`timescale 1ns / 100ps
// testbench top for the luma box blur: clock, reset, register writes, pixel stimulus
// and receiver back-pressure; depends on lbb_pkg, luma_box_blur and luma_box_blur_checker

module luma_box_blur_tb
    import lbb_pkg::*;
();

    localparam int   MAX_WIDTH       = 2048;
    localparam int   RUN_LIMIT_NS    = 50_000_000;
    localparam int   SETTLE_CYCLES   = 8;
    localparam int   RANDOM_ITEMS    = 150;
    localparam int   FILL_WIDTH      = 10;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  pixel_in       = '0;
    logic        start_of_frame = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  pixel_out;
    logic        end_of_line;
    logic        end_of_frame;

    int   mismatches;
    int   outstanding;
    int   pixels_sent = 0;
    int   stall_hold  = 0;
    logic calm        = 1'b0;

    // corner values for the first directed frame
    logic [7:0] corner_frame [9] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
                                     8'd255, 8'd0, 8'd255};

    luma_box_blur #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_in       (pixel_in),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_out      (pixel_out),
        .end_of_line    (end_of_line),
        .end_of_frame   (end_of_frame)
    );

    luma_box_blur_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_in       (pixel_in),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_out      (pixel_out),
        .end_of_line    (end_of_line),
        .end_of_frame   (end_of_frame),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_hold <= idle_length() - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
        end
    end

    // one register write transaction: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // all three registers, with noise in the unused upper bits
    task automatic write_config(input logic m, input logic [11:0] w, input logic [11:0] h);
        write_reg(REG_MODE, {31'($urandom()), m});
        write_reg(REG_WIDTH, {20'($urandom()), w});
        write_reg(REG_HEIGHT, {20'($urandom()), h});
    endtask

    // one pixel transaction, held until accepted
    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        pixel_in       <= pix;
        start_of_frame <= sof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // stop sending until every blurred pixel has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // raster frames of random content, optional stray marks
    task automatic send_frames(input int frames, input int w, input int h, input bit marked,
                               input int stray_pct);
        logic sof;
        for (int f = 0; f < frames; f++)
        begin
            for (int r = 0; r < h; r++)
            begin
                for (int c = 0; c < w; c++)
                begin
                    sof = (marked && r == 0 && c == 0) || ($urandom_range(0, 99) < stray_pct);
                    send_pixel(pick_pixel(), sof);
                    if ($urandom_range(0, 499) == 0)
                        drain();
                end
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int          start;
        int          kind;
        int          ew;
        int          eh;
        logic        m;
        logic [11:0] wr;
        logic [11:0] hr;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two lines at the widest random width fill both line stores
        write_config(MODE_HORIZONTAL, 12'(FILL_WIDTH), 12'd3);
        send_frames(1, FILL_WIDTH, 2, 1'b1, 0);
        drain();

        // directed: smallest frame in box mode, its mark restarts the counters left by the fill
        write_config(MODE_BOX, 12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(corner_frame[i], i == 0);
        // next frame: its first row carries out the last row of the one before
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        // mark in mid-line restarts the frame, first row gives nothing
        send_pixel(8'd254, 1'b1);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd200, 1'b0);
        drain();
        write_config(MODE_HORIZONTAL, 12'd3, 12'd3);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        drain();

        // tallest frame with width below the minimum, cut short by the next mark
        write_config(1'($urandom_range(0, 1)), 12'd0, 12'd4095);
        send_frames(1, 3, 20, 1'b1, 0);
        drain();

        // random phases
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS)
        begin
            m  = 1'($urandom_range(0, 1));
            wr = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                             : 12'($urandom_range(3, FILL_WIDTH));
            hr = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                             : 12'($urandom_range(3, 5));
            write_config(m, wr, hr);
            ew   = (wr < 3) ? 3 : int'(wr);
            eh   = (hr < 3) ? 3 : int'(hr);
            calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                send_frames($urandom_range(1, 2), ew, eh, 1'b1, 0);
            end
            else if (kind < 80)
            begin
                send_frames(1, ew, eh, 1'b1, 4);
            end
            else if (kind < 90)
            begin
                // no marks: counters wrap on their own
                send_frames(2, ew, eh, 1'b0, 0);
            end
            else
            begin
                repeat ($urandom_range(4, 16))
                    send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
            end
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[luma_box_blur.f]
+incdir+hdl
hdl/lbb_pkg.sv
hdl/lbb_line_store.sv
hdl/lbb_out_fifo.sv
hdl/luma_box_blur.sv
tb/sv/luma_box_blur_checker.sv
tb/sv/luma_box_blur_tb.sv
